### rtl/rgbtf_pkg.sv
// ----------------------------------------------------------------------------
// rgbtf_pkg
// Shared types and constants of the 3x3 RGB template filter.
// ----------------------------------------------------------------------------
package rgbtf_pkg;

  localparam int MAX_LINE_PIXELS = 2048;
  localparam int MAX_LINES       = 4096;

  localparam int PIX_W   = 24;
  localparam int COL_W   = $clog2(MAX_LINE_PIXELS);
  localparam int ROW_W   = $clog2(MAX_LINES);
  localparam int WIDTH_W = 12;
  localparam int HEIGHT_W = 13;
  localparam int MODE_W  = 2;
  localparam int PEND_W  = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

  // reset values of the registers
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

  // kernel choice
  localparam logic [MODE_W-1:0] MODE_BOX     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GAUSS   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SHARPEN = 2'd2;

  // item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // floor(x / 9) = (x * RECIP9) >> RECIP9_SHIFT for x below 2296
  localparam int RECIP9_W     = 13;
  localparam logic [RECIP9_W-1:0] RECIP9 = 13'd7282;
  localparam int RECIP9_SHIFT = 16;
  // product of a 12-bit box sum and the reciprocal
  localparam int RECIP9_PROD_W = 12 + RECIP9_W;

  // output queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       frame_end;
  } out_item_t;

  // what travels with a column through the window and kernel
  typedef struct packed {
    logic emit;
    logic inner;
    logic frame_end;
  } tag_t;

  // column request from the sequencer to the line store
  typedef struct packed {
    logic             valid;
    logic             write;
    logic [COL_W-1:0] addr;
    logic [PIX_W-1:0] pix;
    tag_t             tag;
  } col_req_t;

endpackage

### rtl/rgbtf_window.sv
// ----------------------------------------------------------------------------
// rgbtf_window
// Two-line store in one synchronous memory plus the 3x3 window registers.
// ----------------------------------------------------------------------------
module rgbtf_window (
  input  logic                                        clk,
  input  logic                                        rst,
  input  rgbtf_pkg::col_req_t                         req,
  output logic [8:0][rgbtf_pkg::PIX_W-1:0]            win,
  output rgbtf_pkg::tag_t                             tag
);

  // each entry holds {older line, newer line}
  logic [2*rgbtf_pkg::PIX_W-1:0] line_mem [rgbtf_pkg::MAX_LINE_PIXELS];
  logic [2*rgbtf_pkg::PIX_W-1:0] mem_q;
  logic [2*rgbtf_pkg::PIX_W-1:0] fwd_data;
  logic                          fwd_hit;

  logic                          s1_valid;
  logic                          s1_write;
  logic [rgbtf_pkg::COL_W-1:0]   s1_addr;
  logic [rgbtf_pkg::PIX_W-1:0]   s1_pix;
  rgbtf_pkg::tag_t               s1_tag;

  logic [2*rgbtf_pkg::PIX_W-1:0] line_q;
  logic [rgbtf_pkg::PIX_W-1:0]   top_pix;
  logic [rgbtf_pkg::PIX_W-1:0]   mid_pix;
  logic                          wr_en;
  logic [2*rgbtf_pkg::PIX_W-1:0] wr_data;

  logic [8:0][rgbtf_pkg::PIX_W-1:0] win_q;

  // a write in flight to the column being read wins over the memory data
  assign line_q  = fwd_hit ? fwd_data : mem_q;
  assign top_pix = line_q[2*rgbtf_pkg::PIX_W-1:rgbtf_pkg::PIX_W];
  assign mid_pix = line_q[rgbtf_pkg::PIX_W-1:0];
  assign wr_en   = s1_valid & s1_write;
  assign wr_data = {mid_pix, s1_pix};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[s1_addr] <= wr_data;
    end
    if (req.valid) begin
      mem_q <= line_mem[req.addr];
    end
    fwd_hit  <= req.valid & wr_en & (req.addr == s1_addr);
    fwd_data <= wr_data;
    s1_write <= req.write;
    s1_addr  <= req.addr;
    s1_pix   <= req.pix;
    s1_tag   <= req.tag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      tag      <= '0;
      win_q    <= '0;
    end else begin
      s1_valid <= req.valid;
      tag      <= s1_valid ? s1_tag : '0;
      if (s1_valid) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r*3+0] <= win_q[r*3+1];
          win_q[r*3+1] <= win_q[r*3+2];
        end
        win_q[2] <= top_pix;
        win_q[5] <= mid_pix;
        win_q[8] <= s1_pix;
      end
    end
  end

  assign win = win_q;

endmodule

### rtl/rgbtf_kernel.sv
// ----------------------------------------------------------------------------
// rgbtf_kernel
// Per-channel 3x3 sums, then box / gaussian / sharpen selection.
// ----------------------------------------------------------------------------
module rgbtf_kernel (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [8:0][rgbtf_pkg::PIX_W-1:0]     win,
  input  rgbtf_pkg::tag_t                      tag,
  input  logic [rgbtf_pkg::MODE_W-1:0]         mode,
  output logic                                 res_valid,
  output rgbtf_pkg::out_item_t                 res
);

  logic [2:0][11:0] box_sum_c, gauss_sum_c;
  logic [2:0][10:0] nb_sum_c;
  logic [2:0][7:0]  center_c;

  logic [2:0][11:0] box_sum, gauss_sum;
  logic [2:0][10:0] nb_sum;
  logic [2:0][7:0]  center;
  rgbtf_pkg::tag_t  a_tag;

  logic [2:0][7:0]  chan;

  // stage a: sums of the window taps
  always_comb begin
    logic [7:0] v [9];
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 9; i++) begin
        v[i] = win[i][ch*8 +: 8];
      end
      box_sum_c[ch] = {4'b0, v[0]} + {4'b0, v[1]} + {4'b0, v[2]} +
                      {4'b0, v[3]} + {4'b0, v[4]} + {4'b0, v[5]} +
                      {4'b0, v[6]} + {4'b0, v[7]} + {4'b0, v[8]};
      gauss_sum_c[ch] = {4'b0, v[0]} + {3'b0, v[1], 1'b0} + {4'b0, v[2]} +
                        {3'b0, v[3], 1'b0} + {2'b0, v[4], 2'b0} +
                        {3'b0, v[5], 1'b0} + {4'b0, v[6]} +
                        {3'b0, v[7], 1'b0} + {4'b0, v[8]};
      nb_sum_c[ch] = {3'b0, v[0]} + {3'b0, v[1]} + {3'b0, v[2]} +
                     {3'b0, v[3]} + {3'b0, v[5]} + {3'b0, v[6]} +
                     {3'b0, v[7]} + {3'b0, v[8]};
      center_c[ch] = v[4];
    end
  end

  always_ff @(posedge clk) begin
    box_sum   <= box_sum_c;
    gauss_sum <= gauss_sum_c;
    nb_sum    <= nb_sum_c;
    center    <= center_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_tag <= '0;
    end else begin
      a_tag <= tag;
    end
  end

  // stage b: divide, shift or take the magnitude, then pick
  always_comb begin
    logic [11:0] box_w;
    logic [rgbtf_pkg::RECIP9_PROD_W-1:0] prod;
    logic [11:0] c9;
    logic [11:0] mag;
    logic [7:0]  sharp;
    for (int ch = 0; ch < 3; ch++) begin
      box_w = box_sum[ch];
      prod  = {{rgbtf_pkg::RECIP9_W{1'b0}}, box_w} *
              {12'b0, rgbtf_pkg::RECIP9};
      c9    = {1'b0, center[ch], 3'b0} + {4'b0, center[ch]};
      if (c9 >= {1'b0, nb_sum[ch]}) begin
        mag = c9 - {1'b0, nb_sum[ch]};
      end else begin
        mag = {1'b0, nb_sum[ch]} - c9;
      end
      sharp = (mag > 12'd255) ? 8'd255 : mag[7:0];
      if (!a_tag.inner) begin
        chan[ch] = center[ch];
      end else begin
        case (mode)
          rgbtf_pkg::MODE_BOX:     chan[ch] = prod[rgbtf_pkg::RECIP9_SHIFT +: 8];
          rgbtf_pkg::MODE_GAUSS:   chan[ch] = gauss_sum[ch][11:4];
          rgbtf_pkg::MODE_SHARPEN: chan[ch] = sharp;
          default:                 chan[ch] = center[ch];
        endcase
      end
    end
  end

  assign res_valid     = a_tag.emit;
  assign res.out_blue  = chan[0];
  assign res.out_green = chan[1];
  assign res.out_red   = chan[2];
  assign res.frame_end = a_tag.frame_end;

endmodule

### rtl/rgbtf_out_fifo.sv
// ----------------------------------------------------------------------------
// rgbtf_out_fifo
// Small result queue that decouples the kernel from the output handshake.
// ----------------------------------------------------------------------------
module rgbtf_out_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rgbtf_pkg::out_item_t  push_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rgbtf_pkg::out_item_t  out_data
);

  rgbtf_pkg::out_item_t            entries [rgbtf_pkg::FIFO_DEPTH];
  logic [rgbtf_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [rgbtf_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [rgbtf_pkg::FIFO_CNT_W-1:0] count;
  logic                             pop;

  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/rgb_3x3_template_filter_top.sv
// ----------------------------------------------------------------------------
// rgb_3x3_template_filter_top
// Streaming 3x3 box / gaussian / sharpen filter on raster-order BGR pixels.
//
//   channel | signals                       | transfer when
//   --------+-------------------------------+-------------------------
//   input   | in_valid, in_ready, in_data   | in_valid & in_ready
//   output  | out_valid, out_ready, out_data| out_valid & out_ready
//   config  | cfg_we, cfg_index, cfg_data   | cfg_we
//
// One item per cycle while in_ready is high. A result on out_valid passes
// the line memory read, the window shift and the kernel sums registers;
// then the selection writes the output queue.
// Reset clears counters, window and output queue; the line memory is not
// cleared and needs no pass.
// in_ready drops only while eight results are in flight or waiting.
// ----------------------------------------------------------------------------
module rgb_3x3_template_filter_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [rgbtf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rgbtf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  rgbtf_pkg::in_item_t                  in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output rgbtf_pkg::out_item_t                 out_data
);

  logic [rgbtf_pkg::WIDTH_W-1:0]  image_width;
  logic [rgbtf_pkg::HEIGHT_W-1:0] image_height;
  logic [rgbtf_pkg::MODE_W-1:0]   filter_mode;

  logic [rgbtf_pkg::COL_W-1:0]    in_column;
  logic [rgbtf_pkg::COL_W-1:0]    out_column;
  logic [rgbtf_pkg::ROW_W-1:0]    out_row;
  logic [rgbtf_pkg::PEND_W-1:0]   pending;
  logic [rgbtf_pkg::FIFO_CNT_W-1:0] used;

  logic [rgbtf_pkg::WIDTH_W-1:0]  eff_w;
  logic [rgbtf_pkg::HEIGHT_W-1:0] eff_h;
  logic [rgbtf_pkg::WIDTH_W-1:0]  in_col_inc;
  logic [rgbtf_pkg::WIDTH_W-1:0]  out_col_inc;
  logic [rgbtf_pkg::HEIGHT_W-1:0] out_row_inc;
  logic                           in_col_last;
  logic                           out_col_last;
  logic                           out_row_last;

  logic                           accept;
  logic                           is_pixel;
  logic                           emit;
  logic                           out_xfer;

  rgbtf_pkg::col_req_t            req;
  rgbtf_pkg::tag_t                win_tag;
  logic [8:0][rgbtf_pkg::PIX_W-1:0] win;
  logic                           res_valid;
  rgbtf_pkg::out_item_t           res;

  // width and height clamped to the supported range
  always_comb begin
    if (image_width < 12'd3) begin
      eff_w = 12'd3;
    end else if (image_width > 12'(rgbtf_pkg::MAX_LINE_PIXELS)) begin
      eff_w = 12'(rgbtf_pkg::MAX_LINE_PIXELS);
    end else begin
      eff_w = image_width;
    end
    if (image_height < 13'd3) begin
      eff_h = 13'd3;
    end else if (image_height > 13'(rgbtf_pkg::MAX_LINES)) begin
      eff_h = 13'(rgbtf_pkg::MAX_LINES);
    end else begin
      eff_h = image_height;
    end
  end

  assign in_col_inc   = {1'b0, in_column} + 12'd1;
  assign out_col_inc  = {1'b0, out_column} + 12'd1;
  assign out_row_inc  = {1'b0, out_row} + 13'd1;
  assign in_col_last  = (in_col_inc >= eff_w);
  assign out_col_last = (out_col_inc >= eff_w);
  assign out_row_last = (out_row_inc >= eff_h);

  assign in_ready = (used != 4'(rgbtf_pkg::FIFO_DEPTH));
  assign accept   = in_valid & in_ready;
  assign is_pixel = (in_data.item_kind == rgbtf_pkg::KIND_PIXEL);
  assign out_xfer = out_valid & out_ready;

  // a pixel emits once a line plus one pixel is buffered, a flush whenever
  // anything is pending
  assign emit = is_pixel ? (pending >= (eff_w + 12'd1)) : (pending != '0);

  always_comb begin
    req.valid         = accept & (is_pixel | (pending != '0));
    req.write         = is_pixel;
    req.addr          = is_pixel ? in_column :
                        (out_col_last ? '0 : out_col_inc[rgbtf_pkg::COL_W-1:0]);
    req.pix           = is_pixel ? {in_data.in_red, in_data.in_green, in_data.in_blue}
                                 : '0;
    req.tag.emit      = accept & emit;
    req.tag.inner     = (out_row != '0) && !out_row_last &&
                        (out_column != '0) && !out_col_last;
    req.tag.frame_end = out_row_last & out_col_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= rgbtf_pkg::WIDTH_RESET;
      image_height <= rgbtf_pkg::HEIGHT_RESET;
      filter_mode  <= rgbtf_pkg::MODE_BOX;
    end else if (cfg_we) begin
      case (cfg_index)
        rgbtf_pkg::REG_WIDTH:  image_width  <= cfg_data[rgbtf_pkg::WIDTH_W-1:0];
        rgbtf_pkg::REG_HEIGHT: image_height <= cfg_data;
        rgbtf_pkg::REG_MODE:   filter_mode  <= cfg_data[rgbtf_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      out_column <= '0;
      out_row    <= '0;
      pending    <= '0;
    end else if (accept) begin
      if (is_pixel) begin
        in_column <= in_col_last ? '0 : in_col_inc[rgbtf_pkg::COL_W-1:0];
        if (!emit) begin
          pending <= pending + 1'b1;
        end
      end else if (emit) begin
        pending <= pending - 1'b1;
      end
      if (emit) begin
        out_column <= out_col_last ? '0 : out_col_inc[rgbtf_pkg::COL_W-1:0];
        if (out_col_last) begin
          out_row <= out_row_last ? '0 : out_row_inc[rgbtf_pkg::ROW_W-1:0];
        end
      end
    end
  end

  // results accepted but not yet handed out, queue slots reserved up front
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      case ({accept & emit, out_xfer})
        2'b10:   used <= used + 1'b1;
        2'b01:   used <= used - 1'b1;
        default: used <= used;
      endcase
    end
  end

  rgbtf_window u_window (
    .clk (clk),
    .rst (rst),
    .req (req),
    .win (win),
    .tag (win_tag)
  );

  rgbtf_kernel u_kernel (
    .clk       (clk),
    .rst       (rst),
    .win       (win),
    .tag       (win_tag),
    .mode      (filter_mode),
    .res_valid (res_valid),
    .res       (res)
  );

  rgbtf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/rgbtf_checker.sv
// ----------------------------------------------------------------------------
// rgbtf_port_checks
// Port-level checks of the 3x3 template filter, bound to the top level.
// ----------------------------------------------------------------------------
module rgbtf_port_checks (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input rgbtf_pkg::out_item_t             out_data
);

  // reset empties the queue and opens the input
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("queue not empty or input closed after reset");

  // a waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("output result dropped or changed while stalled");

  // input only stalls on results that are bound to reach the output
  a_stall_has_results: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> ##3 out_valid)
    else $error("input stalled without results on the output");

  // the input is never closed for lack of output space while the sink takes
  a_ready_recovers: assert property (@(posedge clk) disable iff (rst)
    (!in_ready && out_valid && out_ready) |=> in_ready)
    else $error("input stayed closed after a result transfer");

endmodule

bind rgb_3x3_template_filter_top rgbtf_port_checks u_rgbtf_port_checks (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### test/rgbtf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgbtf_checker
// Watches the register port and both streams of the 3x3 RGB filter. Keeps a
// raster-order model of the line stores, window and counters, works out each
// output pixel and compares it with the output transfers in order.
// ----------------------------------------------------------------------------
module rgbtf_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rgbtf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgbtf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  rgbtf_pkg::in_item_t              in_data,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  rgbtf_pkg::out_item_t             out_data,
  output int                               fail_count,
  output int                               due_count
);
  import rgbtf_pkg::*;

  localparam int MAX_REPORTS = 10;

  logic [PIX_W-1:0]    upper_line [MAX_LINE_PIXELS];
  logic [PIX_W-1:0]    lower_line [MAX_LINE_PIXELS];
  logic [PIX_W-1:0]    win [9];
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic [MODE_W-1:0]   mode_reg;
  int unsigned         col_in, row_in, col_out, row_out, backlog;
  out_item_t           pixels_due [$];
  int                  mismatches = 0;

  function automatic int unsigned line_len();
    if (width_reg < 3) return 3;
    if (width_reg > MAX_LINE_PIXELS) return MAX_LINE_PIXELS;
    return width_reg;
  endfunction

  function automatic int unsigned frame_lines();
    if (height_reg < 3) return 3;
    if (height_reg > MAX_LINES) return MAX_LINES;
    return height_reg;
  endfunction

  // shift the window left, bring in one column of the two stored lines plus pix
  function automatic void load_column(int unsigned col, logic [PIX_W-1:0] pix, bit store);
    int unsigned      idx;
    logic [PIX_W-1:0] top_pix;
    logic [PIX_W-1:0] mid_pix;
    idx = (col < MAX_LINE_PIXELS) ? col : MAX_LINE_PIXELS - 1;
    top_pix = upper_line[idx];
    mid_pix = lower_line[idx];
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = top_pix;
    win[5] = mid_pix;
    win[8] = pix;
    if (store) begin
      upper_line[idx] = mid_pix;
      lower_line[idx] = pix;
    end
  endfunction

  function automatic logic [7:0] kernel_result(int unsigned sh);
    int tap [9];
    int acc;
    acc = 0;
    for (int i = 0; i < 9; i++) tap[i] = (win[i] >> sh) & 24'hFF;
    case (mode_reg)
      MODE_BOX: begin
        for (int i = 0; i < 9; i++) acc += tap[i];
        return 8'(acc / 9);
      end
      MODE_GAUSS: begin
        // 1-2-1 weights: corners 1, edges 2, center 4
        for (int i = 0; i < 9; i++) acc += tap[i] * ((i == 4) ? 4 : (i % 2) ? 2 : 1);
        return 8'(acc >> 4);
      end
      MODE_SHARPEN: begin
        acc = 9 * tap[4];
        for (int i = 0; i < 9; i++) if (i != 4) acc -= tap[i];
        if (acc < 0) acc = -acc;
        if (acc > 255) acc = 255;
        return 8'(acc);
      end
      default: return 8'(tap[4]);
    endcase
  endfunction

  function automatic out_item_t next_output();
    int unsigned w;
    int unsigned h;
    bit          inner;
    out_item_t   res;
    w = line_len();
    h = frame_lines();
    inner = row_out >= 1 && row_out + 1 < h && col_out >= 1 && col_out + 1 < w;
    res.out_blue  = inner ? kernel_result(0)  : win[4][7:0];
    res.out_green = inner ? kernel_result(8)  : win[4][15:8];
    res.out_red   = inner ? kernel_result(16) : win[4][23:16];
    res.frame_end = (row_out + 1 >= h) && (col_out + 1 >= w);
    if (col_out + 1 >= w) begin
      col_out = 0;
      row_out = (row_out + 1 >= h) ? 0 : row_out + 1;
    end else begin
      col_out++;
    end
    return res;
  endfunction

  function automatic void take_item(in_item_t item);
    int unsigned w;
    w = line_len();
    if (item.item_kind == KIND_PIXEL) begin
      load_column(col_in, {item.in_red, item.in_green, item.in_blue}, 1'b1);
      if (col_in + 1 >= w) begin
        col_in = 0;
        row_in = (row_in + 1 >= frame_lines()) ? 0 : row_in + 1;
      end else begin
        col_in++;
      end
      backlog++;
      // one line plus one pixel behind the input
      if (backlog > w + 1) begin
        pixels_due.push_back(next_output());
        backlog--;
      end
    end else if (backlog != 0) begin
      load_column((col_out + 1 >= w) ? 0 : col_out + 1, '0, 1'b0);
      pixels_due.push_back(next_output());
      backlog--;
    end
  endfunction

  function automatic void check_output(out_item_t got);
    out_item_t want;
    if (pixels_due.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected output transfer: b=%0d g=%0d r=%0d end=%0d",
                 got.out_blue, got.out_green, got.out_red, got.frame_end);
      return;
    end
    want = pixels_due.pop_front();
    if (got.out_blue !== want.out_blue || got.out_green !== want.out_green ||
        got.out_red !== want.out_red || got.frame_end !== want.frame_end) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display({"output mismatch: expected b=%0d g=%0d r=%0d end=%0d,",
                  " got b=%0d g=%0d r=%0d end=%0d"},
                 want.out_blue, want.out_green, want.out_red, want.frame_end,
                 got.out_blue, got.out_green, got.out_red, got.frame_end);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      mode_reg   = MODE_BOX;
      foreach (upper_line[i]) upper_line[i] = '0;
      foreach (lower_line[i]) lower_line[i] = '0;
      foreach (win[i]) win[i] = '0;
      col_in  = 0;
      row_in  = 0;
      col_out = 0;
      row_out = 0;
      backlog = 0;
      pixels_due.delete();
    end else begin
      if (out_valid && out_ready) check_output(out_data);
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:  width_reg  = cfg_data[WIDTH_W-1:0];
          REG_HEIGHT: height_reg = cfg_data[HEIGHT_W-1:0];
          REG_MODE:   mode_reg   = cfg_data[MODE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_item(in_data);
    end
    fail_count <= mismatches;
    due_count  <= pixels_due.size();
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for the 3x3 RGB filter: programs frame size and kernel between
// phases, streams whole frames with random and saturating pixels, drains them
// with flush items, and leaves comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_top;
  import rgbtf_pkg::*;

  localparam int RANDOM_ITEMS  = 1600;
  localparam int IDLE_PCT      = 27;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 1000000;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;

  logic calm       = 1'b0;
  logic squeeze_go = 1'b0;
  logic hold_off   = 1'b0;
  int   fail_count;
  int   due_count;
  int   items_sent  = 0;
  int   cycle_count = 0;

  rgb_3x3_template_filter_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  rgbtf_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_off) begin
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // long receiver stall so the block fills and drops in_ready
  initial begin : squeeze
    wait (squeeze_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("rgb_3x3_template_filter_top regression: fail");
      $finish;
    end
  end

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic in_item_t pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    in_item_t px;
    px.item_kind = KIND_PIXEL;
    px.in_blue   = b;
    px.in_green  = g;
    px.in_red    = r;
    return px;
  endfunction

  function automatic in_item_t flush_item();
    in_item_t fl;
    fl.item_kind = KIND_FLUSH;
    fl.in_blue   = 8'($urandom_range(255));
    fl.in_green  = 8'($urandom_range(255));
    fl.in_red    = 8'($urandom_range(255));
    return fl;
  endfunction

  function automatic logic [7:0] pick_byte(bit harsh);
    logic [7:0] v;
    v = 8'($urandom_range(255));
    if (harsh) v = $urandom_range(1) ? 8'hFF : 8'h00;
    return v;
  endfunction

  task automatic send_item(input in_item_t item);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [WIDTH_W-1:0] wv, input logic [HEIGHT_W-1:0] hv,
                              input logic [MODE_W-1:0] mv);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data  <= {junk[CFG_DATA_W-1], wv};
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data  <= hv;
    @(posedge clk);
    cfg_index <= REG_MODE;
    cfg_data  <= {junk[CFG_DATA_W-1:MODE_W], mv};
    @(posedge clk);
    if ($urandom_range(3) == 0) begin
      cfg_index <= REG_SPARE;
      cfg_data  <= junk;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_frame(int w, int h, bit allow_cut);
    int cut;
    bit harsh;
    cut = -1;
    // early flush only after the first frame at this width has gone in
    if (allow_cut && $urandom_range(99) < 20) cut = int'($urandom_range(w * h - 1, 1));
    harsh = ($urandom_range(3) == 0);
    for (int p = 0; p < w * h; p++) begin
      if (p == cut) send_item(flush_item());
      send_item(pixel(pick_byte(harsh), pick_byte(harsh), pick_byte(harsh)));
    end
  endtask

  task automatic run_phase(input logic [WIDTH_W-1:0] wv, input logic [HEIGHT_W-1:0] hv,
                           input logic [MODE_W-1:0] mv, input int frames);
    int w;
    int h;
    w = clamp(int'(wv), 3, MAX_LINE_PIXELS);
    h = clamp(int'(hv), 3, MAX_LINES);
    program_regs(wv, hv, mv);
    for (int f = 0; f < frames; f++) send_frame(w, h, f > 0);
    // drain the tail, sometimes with spare flushes that find nothing
    repeat (w + 1 + $urandom_range(2)) send_item(flush_item());
    wait_idle();
  endtask

  initial begin : stimulus
    int                  first;
    int                  done;
    int                  pick;
    logic [WIDTH_W-1:0]  wv;
    logic [HEIGHT_W-1:0] hv;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sharpen saturation both ways on the smallest frame, frames back to back
    program_regs(12'd3, 13'd3, MODE_SHARPEN);
    send_item(flush_item());
    for (int p = 0; p < 9; p++)
      send_item((p == 4) ? pixel(8'hFF, 8'hFF, 8'hFF) : pixel(8'h00, 8'h00, 8'h00));
    for (int p = 0; p < 9; p++)
      send_item((p == 4) ? pixel(8'h00, 8'h00, 8'h00) : pixel(8'hFF, 8'd30, 8'h00));
    repeat (5) send_item(flush_item());
    wait_idle();

    first = items_sent;
    done  = 0;
    while (done < RANDOM_ITEMS) begin
      calm <= (done >= 800 && done < 1000);
      if (done >= 300) squeeze_go <= 1'b1;
      pick = $urandom_range(99);
      if (pick < 8) begin
        wv = WIDTH_W'($urandom_range(2));
      end else if (pick < 14) begin
        wv = WIDTH_W'($urandom_range(64, 13));
      end else begin
        wv = WIDTH_W'($urandom_range(12, 3));
      end
      hv = ($urandom_range(99) < 8) ? HEIGHT_W'($urandom_range(2))
                                    : HEIGHT_W'($urandom_range(6, 3));
      run_phase(wv, hv, MODE_W'($urandom_range(3)), int'($urandom_range(3, 1)));
      done = items_sent - first;
    end
    calm <= 1'b0;

    if (fail_count == 0 && due_count == 0) begin
      $display("rgb_3x3_template_filter_top regression: pass");
    end else begin
      $display("rgb_3x3_template_filter_top regression: fail");
    end
    $finish;
  end

endmodule
